[hdl/pre_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor package
// Shared widths, character constants and the controller/datapath structs.
// ---------------------------------------------------------------------------
package pre_pkg;

   localparam int BYTE_W    = 8;
   localparam int MIN_LEN_W = 6;

   localparam logic [BYTE_W-1:0]    CHAR_LF       = 8'd10;
   localparam logic [BYTE_W-1:0]    CHAR_CR       = 8'd13;
   localparam logic [BYTE_W-1:0]    PRINT_LO      = 8'd32;
   localparam logic [BYTE_W-1:0]    PRINT_HI      = 8'd126;
   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd10;

   typedef enum logic [1:0] {
      SEL_INPUT,
      SEL_BUFFER,
      SEL_TERM
   } out_sel_type;

   typedef struct packed {
      logic        take;         // an input transfer happens this cycle
      logic        run_advance;  // store the byte and extend the run
      logic        run_clear;    // close the run
      logic        idx_clear;
      logic        idx_inc;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic byte_ok;
      logic eos;
      logic eos_held;
      logic passing;
      logic fills;
      logic idx_last;
      logic out_free;
   } status_type;

endpackage

[hdl/pre_channels.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor channels
// Valid/ready interfaces for the byte input and the result output.
// ---------------------------------------------------------------------------
interface pre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface pre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_terminator;
   logic       last_of_burst;

   modport source (output valid, output out_byte, output is_terminator,
                    output last_of_burst, input ready);
   modport sink   (input valid, input out_byte, input is_terminator,
                   input last_of_burst, output ready);
endinterface

[hdl/pre_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pre_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor controller
// Sequences input transfers, the buffer drain burst and terminators.
// ---------------------------------------------------------------------------
module pre_ctrl
   import pre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_DRAIN,
      ST_TERM
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;

   always_comb begin
      cmd      = '0;
      cmd.out_sel = SEL_INPUT;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.out_free) begin
               cmd.take = 1'b1;
               if (status.byte_ok && status.passing) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = SEL_INPUT;
                  cmd.out_last = !status.eos;
                  if (status.eos) begin
                     cmd.run_clear = 1'b1;
                     state_in      = ST_TERM;
                  end
               end else if (status.byte_ok) begin
                  cmd.run_advance = 1'b1;
                  if (status.fills) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_PRIME;
                  end else if (status.eos) begin
                     cmd.run_clear = 1'b1;
                  end
               end else begin
                  cmd.run_clear = 1'b1;
                  if (status.passing) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = SEL_TERM;
                     cmd.out_last = 1'b1;
                  end
               end
            end
         end
         // The buffer read address settles here, so the first byte is ready in the drain.
         ST_PRIME: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_BUFFER;
               cmd.idx_inc  = 1'b1;
               cmd.out_last = status.idx_last && !status.eos_held;
               if (status.idx_last) begin
                  if (status.eos_held) begin
                     cmd.run_clear = 1'b1;
                     state_in      = ST_TERM;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_TERM;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/pre_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor datapath
// Run buffer, run length, drain index, minimum length register and result
// output register.
// ---------------------------------------------------------------------------
module pre_dp
   import pre_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BYTE_W-1:0]    in_byte,
   input  logic                 end_of_stream,
   input  logic                 csr_write_enable,
   input  logic [MIN_LEN_W-1:0] csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    out_byte,
   output logic                 is_terminator,
   output logic                 last_of_burst,
   input  cmd_type              cmd,
   output status_type           status
);

   localparam int ADDR_W = (MAX_MIN_LENGTH > 1) ? $clog2(MAX_MIN_LENGTH) : 1;
   localparam int LEN_W  = $clog2(MAX_MIN_LENGTH + 1);

   logic [MIN_LEN_W-1:0] min_length_ff;
   logic [LEN_W-1:0]     run_length_ff, run_length_in;
   logic                 passing_ff, passing_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic                 eos_ff;
   logic                 rsp_valid_ff;
   logic [BYTE_W-1:0]    out_byte_ff;
   logic                 term_ff;
   logic                 last_ff;

   logic [LEN_W-1:0]     eff_min;
   logic [LEN_W-1:0]     len_after;
   logic                 can_store;
   logic                 byte_ok;
   logic [BYTE_W-1:0]    buf_data;

   always_comb begin
      if (min_length_ff == '0) begin
         eff_min = LEN_W'(1);
      end else if ({1'b0, min_length_ff} > (MIN_LEN_W + 1)'(MAX_MIN_LENGTH)) begin
         eff_min = LEN_W'(MAX_MIN_LENGTH);
      end else begin
         eff_min = LEN_W'(min_length_ff);
      end
   end

   assign byte_ok = ((in_byte >= PRINT_LO) && (in_byte <= PRINT_HI)) ||
                    (in_byte == CHAR_LF) || (in_byte == CHAR_CR);

   assign can_store = run_length_ff < LEN_W'(MAX_MIN_LENGTH);
   assign len_after = can_store ? run_length_ff + LEN_W'(1) : run_length_ff;

   always_comb begin
      run_length_in = run_length_ff;
      passing_in    = passing_ff;
      if (cmd.run_clear) begin
         run_length_in = '0;
         passing_in    = 1'b0;
      end else if (cmd.run_advance) begin
         run_length_in = len_after;
         if (len_after >= eff_min) begin
            passing_in = 1'b1;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   // The read address runs one step ahead so that the registered data matches idx_ff.
   pre_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_MIN_LENGTH)
   ) u_run_buffer (
      .clock   (clock),
      .wr_en   (cmd.run_advance && can_store),
      .wr_addr (run_length_ff[ADDR_W-1:0]),
      .wr_data (in_byte),
      .rd_addr (idx_in),
      .rd_data (buf_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LEN_RESET;
         run_length_ff <= '0;
         passing_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            min_length_ff <= csr_write_data;
         end
         run_length_ff <= run_length_in;
         passing_ff    <= passing_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.take) begin
         eos_ff <= end_of_stream;
      end
      if (cmd.out_load) begin
         last_ff <= cmd.out_last;
         case (cmd.out_sel)
            SEL_INPUT: begin
               out_byte_ff <= in_byte;
               term_ff     <= 1'b0;
            end
            SEL_BUFFER: begin
               out_byte_ff <= buf_data;
               term_ff     <= 1'b0;
            end
            SEL_TERM: begin
               out_byte_ff <= CHAR_LF;
               term_ff     <= 1'b1;
            end
            default: begin
               out_byte_ff <= CHAR_LF;
               term_ff     <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign out_byte      = out_byte_ff;
   assign is_terminator = term_ff;
   assign last_of_burst = last_ff;

   assign status.byte_ok  = byte_ok;
   assign status.eos      = end_of_stream;
   assign status.eos_held = eos_ff;
   assign status.passing  = passing_ff;
   assign status.fills    = len_after >= eff_min;
   assign status.idx_last = (LEN_W'(idx_ff) + LEN_W'(1)) == run_length_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

[hdl/printable_run_extractor_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor core
// Passes on every run of printable bytes (32 to 126, LF, CR) that reaches
// the programmed minimum length, each followed by a newline terminator.
//
//   Channel  | Dir | Handshake         | Payload
//   ---------+-----+-------------------+----------------------------------
//   req_ch   | in  | valid / ready     | in_byte, end_of_stream
//   rsp_ch   | out | valid / ready     | out_byte, is_terminator, last_of_burst
//   csr_*    | in  | write enable only | min_length (6 bits)
//
// A passing byte goes straight to the result register; a byte that is only
// buffered goes to the run buffer. A completing byte starts the drain: a
// prime state sets up the registered RAM read, then one buffered byte per
// cycle goes out while the output is free. An end-of-stream terminator has
// its own state. Reset clears the run state and loads min_length with 10;
// the buffer needs no clearing. A stalled output holds the next input back.
// ---------------------------------------------------------------------------
module printable_run_extractor_core
   import pre_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   pre_req_if.sink              req_ch,
   pre_rsp_if.source            rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [MIN_LEN_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   pre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pre_dp #(
      .MAX_MIN_LENGTH (MAX_MIN_LENGTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .in_byte          (req_ch.in_byte),
      .end_of_stream    (req_ch.end_of_stream),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .out_byte         (rsp_ch.out_byte),
      .is_terminator    (rsp_ch.is_terminator),
      .last_of_burst    (rsp_ch.last_of_burst),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

[verif/printable_run_extractor_core_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor checker
// Watches the byte and result channels and the min_length port. Keeps its own
// copy of the run state and predicts the results of every accepted byte. Each
// result transfer is compared field by field with the oldest predicted one.
// ---------------------------------------------------------------------------
module printable_run_extractor_core_checker
   import pre_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   pre_req_if                   req_ch,
   pre_rsp_if                   rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [MIN_LEN_W-1:0] csr_write_data,
   output int                   fail_count,
   output int                   results_owed
);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_terminator;
      logic              last_of_burst;
   } run_result_type;

   run_result_type       owed_results[$];
   logic [BYTE_W-1:0]    run_bytes[MAX_MIN_LENGTH];
   int                   held_count;
   logic                 passing;
   logic [MIN_LEN_W-1:0] min_length;

   initial begin
      fail_count   = 0;
      results_owed = 0;
   end

   function automatic logic is_printable(logic [BYTE_W-1:0] b);
      return (b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR;
   endfunction

   // Work out what one accepted byte causes and queue it behind earlier results.
   function automatic void extract_from_byte(logic [BYTE_W-1:0] b, logic eos);
      run_result_type burst[$];
      int             threshold;
      threshold = (min_length == 0) ? 1 :
                  ((int'(min_length) > MAX_MIN_LENGTH) ? MAX_MIN_LENGTH : int'(min_length));
      if (is_printable(b)) begin
         if (passing) begin
            burst.push_back('{b, 1'b0, 1'b0});
         end else begin
            if (held_count < MAX_MIN_LENGTH) begin
               run_bytes[held_count] = b;
               held_count++;
            end
            if (held_count >= threshold) begin
               for (int i = 0; i < held_count; i++)
                  burst.push_back('{run_bytes[i], 1'b0, 1'b0});
               passing = 1'b1;
            end
         end
         if (eos) begin
            if (passing)
               burst.push_back('{CHAR_LF, 1'b1, 1'b0});
            passing    = 1'b0;
            held_count = 0;
         end
      end else begin
         if (passing)
            burst.push_back('{CHAR_LF, 1'b1, 1'b0});
         passing    = 1'b0;
         held_count = 0;
      end
      if (burst.size() > 0)
         burst[burst.size()-1].last_of_burst = 1'b1;
      foreach (burst[i])
         owed_results.push_back(burst[i]);
   endfunction

   // Result transfers are checked before the byte of the same edge is
   // predicted, since a result can only belong to an earlier byte.
   always @(posedge clock) begin
      run_result_type want;
      if (reset) begin
         owed_results.delete();
         held_count = 0;
         passing    = 1'b0;
         min_length = MIN_LEN_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result: out_byte %0d, is_terminator %0d",
                      rsp_ch.out_byte, rsp_ch.is_terminator);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_ch.out_byte);
                  fail_count++;
               end
               if (rsp_ch.is_terminator !== want.is_terminator) begin
                  $error("is_terminator: expected %0d, got %0d",
                         want.is_terminator, rsp_ch.is_terminator);
                  fail_count++;
               end
               if (rsp_ch.last_of_burst !== want.last_of_burst) begin
                  $error("last_of_burst: expected %0d, got %0d",
                         want.last_of_burst, rsp_ch.last_of_burst);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            extract_from_byte(req_ch.in_byte, req_ch.end_of_stream);
         if (csr_write_enable)
            min_length = csr_write_data;
      end
      results_owed = owed_results.size();
   end

endmodule

[verif/printable_run_extractor_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Printable run extractor testbench
// Drives a directed byte sequence and then random runs, noise and stream ends
// under several min_length settings, with random gaps on the byte channel and
// random stalls on the result channel. The checker does all prediction.
// ---------------------------------------------------------------------------
module printable_run_extractor_core_tb;
   import pre_pkg::*;

   localparam int RUN_BUF_DEPTH = 32;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [MIN_LEN_W-1:0] csr_write_data;
   int                   fail_count;
   int                   results_owed;
   logic                 steady;
   int                   active_min;

   pre_req_if req_ch ();
   pre_rsp_if rsp_ch ();

   printable_run_extractor_core #(
      .MAX_MIN_LENGTH(RUN_BUF_DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   printable_run_extractor_core_checker #(
      .MAX_MIN_LENGTH(RUN_BUF_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .results_owed    (results_owed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_500_000;
      $display("printable_run_extractor_core_tb: done, errors");
      $finish;
   end

   // Result side: mostly short ready and stall stretches, with the odd long one.
   initial begin
      int roll;
      int span;
      logic level;
      rsp_ch.ready = 1'b0;
      forever begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            level = 1'b1;
            span  = $urandom_range(1, 8);
         end else if (roll < 70) begin
            level = 1'b1;
            span  = $urandom_range(40, 120);
         end else if (roll < 95) begin
            level = 1'b0;
            span  = $urandom_range(1, 3);
         end else begin
            level = 1'b0;
            span  = $urandom_range(10, 30);
         end
         @(negedge clock);
         rsp_ch.ready <= level;
         repeat (span - 1) @(negedge clock);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 70)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 25);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_printable();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return CHAR_LF;
      else if (roll < 10)
         return CHAR_CR;
      else
         return BYTE_W'($urandom_range(PRINT_LO, PRINT_HI));
   endfunction

   function automatic logic [BYTE_W-1:0] pick_reject();
      logic [BYTE_W-1:0] b;
      do
         b = BYTE_W'($urandom_range(0, 255));
      while ((b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR);
      return b;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   // with valid still high, so back-to-back bytes follow without a gap.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.end_of_stream <= eos;
      do
         @(posedge clock);
      while (!req_ch.ready);
      @(negedge clock);
   endtask

   // The register is only written once all results are out and the drain of
   // any last buffered byte has had time to finish.
   task automatic write_min_length(input logic [MIN_LEN_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (results_owed != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_min = (value == 0) ? 1 :
                   ((int'(value) > RUN_BUF_DEPTH) ? RUN_BUF_DEPTH : int'(value));
   endtask

   // One printable run near the threshold with a random close, or a burst of
   // raw noise.
   task automatic send_sequence(inout int sent);
      int roll;
      int close_kind;
      int len;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         len        = $urandom_range((active_min > 3) ? active_min - 3 : 1, active_min + 6);
         close_kind = $urandom_range(0, 99);
         for (int i = 0; i < len; i++)
            send_byte(pick_printable(), close_kind < 25 && i == len - 1);
         sent += len;
         if (close_kind >= 25 && close_kind < 90) begin
            send_byte(pick_reject(), close_kind >= 75);
            sent++;
         end
      end else begin
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         sent += len;
      end
   endtask

   initial begin
      logic [MIN_LEN_W-1:0] phase_mins[8];
      int sent;
      int budget;
      int wait_cycles;

      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_ch.valid         = 1'b0;
      req_ch.in_byte       = '0;
      req_ch.end_of_stream = 1'b0;
      steady               = 1'b0;
      active_min           = int'(MIN_LEN_RESET);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset threshold: rejected extremes, then a short run dropped silently.
      send_byte(8'd0, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte("a", 1'b0);
      send_byte("b", 1'b0);
      send_byte(8'd31, 1'b0);

      // Zero acts as one: every printable byte passes at once.
      write_min_length(6'd0);
      send_byte(PRINT_LO, 1'b0);
      send_byte(PRINT_HI, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte(8'd127, 1'b0);
      send_byte(8'd31, 1'b0);
      send_byte("x", 1'b1);
      send_byte(8'd128, 1'b1);

      // Threshold two: short run closed by end of stream, a stream end on a
      // rejected byte, and a run completed by its own end-of-stream byte.
      write_min_length(6'd2);
      send_byte("q", 1'b1);
      send_byte("r", 1'b0);
      send_byte("s", 1'b0);
      send_byte(8'd255, 1'b1);
      send_byte("u", 1'b0);
      send_byte("v", 1'b1);

      // A buffered byte left over when the threshold drops to one.
      send_byte("w", 1'b0);
      write_min_length(6'd1);
      send_byte("y", 1'b0);
      send_byte(8'd0, 1'b0);

      phase_mins[0] = 6'd63;
      phase_mins[1] = 6'd1;
      phase_mins[2] = 6'd32;
      phase_mins[3] = 6'd4;
      phase_mins[4] = MIN_LEN_W'($urandom_range(0, 63));
      phase_mins[5] = MIN_LEN_W'($urandom_range(2, 12));
      phase_mins[6] = 6'd0;
      phase_mins[7] = MIN_LEN_W'($urandom_range(2, 20));

      foreach (phase_mins[p]) begin
         write_min_length(phase_mins[p]);
         steady = ($urandom_range(0, 3) == 0);
         budget = (active_min > 16) ? 20 : 8;
         sent   = 0;
         while (sent < budget)
            send_sequence(sent);
      end

      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (results_owed != 0 && wait_cycles < 5000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0 && results_owed == 0)
         $display("printable_run_extractor_core_tb: done, clean");
      else
         $display("printable_run_extractor_core_tb: done, errors");
      $finish;
   end

endmodule
